// ===== sv/opu_pkg.sv =====
// Shared types, constants and saturation helper for the optimizer update pipeline.
package opu_pkg;

	localparam int DATA_W = 32;
	localparam int FRAC_W = 24;
	localparam int CORR_W = 16;
	localparam int ROOT_W = 28;
	localparam int ARG_W = 2 * ROOT_W;
	localparam int DEN_W = ROOT_W + 1;
	localparam int QUO_W = 56;
	localparam int NUM_W = 57;
	localparam int WIDE_W = 72;
	localparam int ADDR_W = 5;

	typedef logic signed [DATA_W-1:0] data_t;

	typedef enum logic [1:0] {
		MODE_SGD,
		MODE_MOMENTUM,
		MODE_ADAM,
		MODE_NONE
	} mode_t;

	typedef enum logic [2:0] {
		REG_MODE,
		REG_LR,
		REG_MF,
		REG_B1,
		REG_B2,
		REG_EPS,
		REG_C1,
		REG_C2
	} reg_idx_t;

	typedef struct packed {
		mode_t       mode;
		logic [23:0] lr;
		logic [23:0] mf;
		logic [23:0] b1;
		logic [23:0] b2;
		logic [23:0] eps;
		logic [31:0] c1;
		logic [31:0] c2;
	} cfg_t;

	// Item fields carried alongside the Adam datapath
	typedef struct packed {
		mode_t                   mode;
		data_t                   p;
		data_t                   nm;
		data_t                   nv;
		data_t                   np;
		logic                    flag;
		logic signed [NUM_W-1:0] num;
	} side_t;

	typedef struct packed {
		data_t val;
		logic  clip;
	} sat_t;

	localparam logic signed [WIDE_W-1:0] DMAX = WIDE_W'((64'sd1 <<< (DATA_W - 1)) - 64'sd1);
	localparam logic signed [WIDE_W-1:0] DMIN = -DMAX - WIDE_W'(1);

	// Clip a wide signed value to the data range
	function automatic sat_t sat_wide(input logic signed [WIDE_W-1:0] x);
		sat_t r;
		if (x > DMAX) begin
			r.val  = DMAX[DATA_W-1:0];
			r.clip = 1'b1;
		end else if (x < DMIN) begin
			r.val  = DMIN[DATA_W-1:0];
			r.clip = 1'b1;
		end else begin
			r.val  = x[DATA_W-1:0];
			r.clip = 1'b0;
		end
		return r;
	endfunction

endpackage

// ===== sv/opu_cfg.sv =====
// APB register file holding the optimizer settings.
module opu_cfg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [opu_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	output opu_pkg::cfg_t              cfg
);
	import opu_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr;

	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode <= MODE_SGD;
			cfg_q.lr   <= 24'd16777;
			cfg_q.mf   <= 24'd15099494;
			cfg_q.b1   <= 24'd15099494;
			cfg_q.b2   <= 24'd16760439;
			cfg_q.eps  <= 24'd1;
			cfg_q.c1   <= 32'd65536;
			cfg_q.c2   <= 32'd65536;
		end else if (wr) begin
			unique case (idx)
				REG_MODE: cfg_q.mode <= mode_t'(pwdata[1:0]);
				REG_LR:   cfg_q.lr   <= pwdata[23:0];
				REG_MF:   cfg_q.mf   <= pwdata[23:0];
				REG_B1:   cfg_q.b1   <= pwdata[23:0];
				REG_B2:   cfg_q.b2   <= pwdata[23:0];
				REG_EPS:  cfg_q.eps  <= pwdata[23:0];
				REG_C1:   cfg_q.c1   <= pwdata;
				REG_C2:   cfg_q.c2   <= pwdata;
				default:  ;
			endcase
		end
	end

	// Read mux
	always_comb begin
		unique case (idx)
			REG_MODE: prdata = {30'd0, cfg_q.mode};
			REG_LR:   prdata = {8'd0, cfg_q.lr};
			REG_MF:   prdata = {8'd0, cfg_q.mf};
			REG_B1:   prdata = {8'd0, cfg_q.b1};
			REG_B2:   prdata = {8'd0, cfg_q.b2};
			REG_EPS:  prdata = {8'd0, cfg_q.eps};
			REG_C1:   prdata = cfg_q.c1;
			REG_C2:   prdata = cfg_q.c2;
			default:  prdata = '0;
		endcase
	end

endmodule

// ===== sv/opu_front.sv =====
// Six-stage multiply/saturate front end: SGD, momentum and Adam moment math.
module opu_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  opu_pkg::cfg_t             cfg,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  opu_pkg::data_t            p_in,
	input  opu_pkg::data_t            g_in,
	input  opu_pkg::data_t            m_in,
	input  opu_pkg::data_t            v_in,
	output logic                      out_valid,
	input  logic                      out_ready,
	output opu_pkg::side_t            out_side,
	output logic [opu_pkg::ARG_W-1:0] out_arg
);
	import opu_pkg::*;

	localparam logic [24:0] ONE_Q = 25'd16777216;

	typedef struct packed {
		mode_t               mode;
		data_t               p, g, m, v;
		logic signed [56:0]  lrg, mfv, b1m, b2v;
		logic signed [57:0]  ob1g;
		logic signed [63:0]  gg;
	} st1_t;

	typedef struct packed {
		mode_t               mode;
		data_t               p, m, v;
		logic signed [56:0]  b2v;
		sat_t                np_sgd, nv_mom, nm_a;
		logic [39:0]         g2;
	} st2_t;

	typedef struct packed {
		side_t               side;
		logic signed [56:0]  b2v;
		logic [64:0]         ob2g;
		logic signed [64:0]  mprod;
	} st3_t;

	typedef struct packed {
		side_t               side;
	} st4_t;

	typedef struct packed {
		side_t               side;
		logic signed [64:0]  vprod;
	} st5_t;

	typedef struct packed {
		side_t               side;
		logic [ARG_W-1:0]    arg;
	} st6_t;

	logic [5:0] v_q;
	logic [5:0] en;
	st1_t s1, d1_s1;
	st2_t s2, d2_s2;
	st3_t s3, d3_s3;
	st4_t s4, d4_s4;
	st5_t s5, d5_s5;
	st6_t s6, d6_s6;

	// Stall chain: a stage loads when it is empty or its successor moves
	always_comb begin
		en[5] = !v_q[5] || out_ready;
		for (int k = 4; k >= 0; k--) begin
			en[k] = !v_q[k] || en[k+1];
		end
	end

	assign in_ready  = en[0];
	assign out_valid = v_q[5];
	assign out_side  = d6_s6.side;
	assign out_arg   = d6_s6.arg;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[0]) v_q[0] <= in_valid;
			for (int k = 1; k < 6; k++) begin
				if (en[k]) v_q[k] <= v_q[k-1];
			end
		end
	end

	// Stage 1: raw products
	always_comb begin
		logic [24:0] ob1;
		ob1      = ONE_Q - {1'b0, cfg.b1};
		s1.mode  = cfg.mode;
		s1.p     = p_in;
		s1.g     = g_in;
		s1.m     = m_in;
		s1.v     = v_in;
		s1.lrg   = $signed({1'b0, cfg.lr}) * g_in;
		s1.mfv   = $signed({1'b0, cfg.mf}) * v_in;
		s1.b1m   = $signed({1'b0, cfg.b1}) * m_in;
		s1.b2v   = $signed({1'b0, cfg.b2}) * v_in;
		s1.ob1g  = $signed({1'b0, ob1}) * g_in;
		s1.gg    = g_in * g_in;
	end

	// Stage 2: SGD result, momentum velocity, Adam first moment
	always_comb begin
		logic signed [57:0] dv;
		logic signed [58:0] em;
		dv         = 58'(d1_s1.mfv) - 58'(d1_s1.lrg);
		em         = 59'(d1_s1.b1m) + 59'(d1_s1.ob1g);
		s2.mode    = d1_s1.mode;
		s2.p       = d1_s1.p;
		s2.m       = d1_s1.m;
		s2.v       = d1_s1.v;
		s2.b2v     = d1_s1.b2v;
		s2.np_sgd  = sat_wide(WIDE_W'(d1_s1.p) - WIDE_W'(d1_s1.lrg >>> FRAC_W));
		s2.nv_mom  = sat_wide(WIDE_W'(dv >>> FRAC_W));
		s2.nm_a    = sat_wide(WIDE_W'(em >>> FRAC_W));
		s2.g2      = d1_s1.gg[63:24];
	end

	// Stage 3: momentum parameter, per-mode defaults, Adam products
	always_comb begin
		logic [24:0] ob2;
		sat_t        np_mom;
		ob2    = ONE_Q - {1'b0, cfg.b2};
		np_mom = sat_wide(WIDE_W'(d2_s2.p) + WIDE_W'(d2_s2.nv_mom.val));
		s3.side.mode = d2_s2.mode;
		s3.side.p    = d2_s2.p;
		s3.side.num  = '0;
		s3.side.nm   = d2_s2.m;
		s3.side.nv   = d2_s2.v;
		s3.side.np   = d2_s2.p;
		s3.side.flag = 1'b0;
		case (d2_s2.mode)
			MODE_SGD: begin
				s3.side.np   = d2_s2.np_sgd.val;
				s3.side.flag = d2_s2.np_sgd.clip;
			end
			MODE_MOMENTUM: begin
				s3.side.np   = np_mom.val;
				s3.side.nv   = d2_s2.nv_mom.val;
				s3.side.flag = d2_s2.nv_mom.clip | np_mom.clip;
			end
			MODE_ADAM: begin
				s3.side.nm   = d2_s2.nm_a.val;
				s3.side.flag = d2_s2.nm_a.clip;
			end
			default: ;
		endcase
		s3.b2v   = d2_s2.b2v;
		s3.ob2g  = ob2 * d2_s2.g2;
		s3.mprod = d2_s2.nm_a.val * $signed({1'b0, cfg.c1});
	end

	// Stage 4: Adam second moment and corrected first moment
	always_comb begin
		logic signed [66:0] sv;
		sat_t               nv_a;
		sat_t               mh;
		sv      = 67'(d3_s3.b2v) + $signed({2'b0, d3_s3.ob2g});
		nv_a    = sat_wide(WIDE_W'(sv >>> FRAC_W));
		mh      = sat_wide(WIDE_W'(d3_s3.mprod >>> CORR_W));
		s4.side = d3_s3.side;
		if (d3_s3.side.mode == MODE_ADAM) begin
			s4.side.nv   = nv_a.val;
			s4.side.np   = mh.val;
			s4.side.flag = d3_s3.side.flag | nv_a.clip | mh.clip;
		end
	end

	// Stage 5: step numerator and corrected second moment product
	always_comb begin
		s5.side     = d4_s4.side;
		s5.side.num = $signed({1'b0, cfg.lr}) * d4_s4.side.np;
		s5.vprod    = d4_s4.side.nv * $signed({1'b0, cfg.c2});
		// Adam parked the corrected first moment in np; put the old parameter back
		if (d4_s4.side.mode == MODE_ADAM) s5.side.np = d4_s4.side.p;
	end

	// Stage 6: saturate corrected second moment, form root argument
	always_comb begin
		sat_t vh;
		vh      = sat_wide(WIDE_W'(d5_s5.vprod >>> CORR_W));
		s6.side = d5_s5.side;
		s6.arg  = '0;
		if (d5_s5.side.mode == MODE_ADAM) begin
			s6.side.flag = d5_s5.side.flag | vh.clip;
			if (vh.val > 0) s6.arg = {1'b0, vh.val[30:0], 24'd0};
		end
	end

	// Pipeline registers
	always_ff @(posedge clk) begin
		if (en[0]) d1_s1 <= s1;
		if (en[1]) d2_s2 <= s2;
		if (en[2]) d3_s3 <= s3;
		if (en[3]) d4_s4 <= s4;
		if (en[4]) d5_s5 <= s5;
		if (en[5]) d6_s6 <= s6;
	end

endmodule

// ===== sv/opu_sqrt.sv =====
// Pipelined integer square root, two radicand bits per stage, then adds epsilon.
module opu_sqrt (
	input  logic                      clk,
	input  logic                      arst_n,
	input  opu_pkg::cfg_t             cfg,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  opu_pkg::side_t            in_side,
	input  logic [opu_pkg::ARG_W-1:0] in_arg,
	output logic                      out_valid,
	input  logic                      out_ready,
	output opu_pkg::side_t            out_side,
	output logic [opu_pkg::DEN_W-1:0] out_den
);
	import opu_pkg::*;

	localparam int N = ROOT_W;

	typedef struct packed {
		side_t             side;
		logic [ARG_W-1:0]  arg;
		logic [31:0]       rem;
		logic [ROOT_W-1:0] root;
	} sq_t;

	logic [N-1:0] v_q;
	logic [N-1:0] en;
	sq_t          st_q [N];
	sq_t          nx   [N];

	always_comb begin
		en[N-1] = !v_q[N-1] || out_ready;
		for (int k = N - 2; k >= 0; k--) begin
			en[k] = !v_q[k] || en[k+1];
		end
	end

	assign in_ready  = en[0];
	assign out_valid = v_q[N-1];
	assign out_side  = st_q[N-1].side;
	assign out_den   = {1'b0, st_q[N-1].root} + {5'd0, cfg.eps};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[0]) v_q[0] <= in_valid;
			for (int k = 1; k < N; k++) begin
				if (en[k]) v_q[k] <= v_q[k-1];
			end
		end
	end

	// One root bit per stage
	for (genvar k = 0; k < N; k++) begin : g_stage
		sq_t src;
		if (k == 0) begin : g_first
			always_comb begin
				src.side = in_side;
				src.arg  = in_arg;
				src.rem  = '0;
				src.root = '0;
			end
		end else begin : g_rest
			assign src = st_q[k-1];
		end

		always_comb begin
			logic [31:0] r2;
			logic [31:0] trial;
			r2       = {src.rem[29:0], src.arg[ARG_W-1 -: 2]};
			trial    = {2'b00, src.root, 2'b01};
			nx[k]      = src;
			nx[k].arg  = {src.arg[ARG_W-3:0], 2'b00};
			if (r2 >= trial) begin
				nx[k].rem  = r2 - trial;
				nx[k].root = {src.root[ROOT_W-2:0], 1'b1};
			end else begin
				nx[k].rem  = r2;
				nx[k].root = {src.root[ROOT_W-2:0], 1'b0};
			end
		end

		always_ff @(posedge clk) begin
			if (en[k]) st_q[k] <= nx[k];
		end
	end

endmodule

// ===== sv/opu_div.sv =====
// Pipelined restoring divider for the Adam step, one quotient bit per stage.
module opu_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  opu_pkg::side_t            in_side,
	input  logic [opu_pkg::DEN_W-1:0] in_den,
	output logic                      out_valid,
	input  logic                      out_ready,
	output opu_pkg::side_t            out_side,
	output logic [opu_pkg::QUO_W-1:0] out_quo,
	output logic                      out_neg,
	output logic                      out_dz
);
	import opu_pkg::*;

	localparam int N = QUO_W;

	typedef struct packed {
		side_t            side;
		logic [DEN_W-1:0] den;
		logic [DEN_W-1:0] rem;
		logic [QUO_W-1:0] word;
		logic             neg;
	} dv_t;

	logic [N-1:0] v_q;
	logic [N-1:0] en;
	dv_t          st_q [N];
	dv_t          nx   [N];

	always_comb begin
		en[N-1] = !v_q[N-1] || out_ready;
		for (int k = N - 2; k >= 0; k--) begin
			en[k] = !v_q[k] || en[k+1];
		end
	end

	assign in_ready  = en[0];
	assign out_valid = v_q[N-1];
	assign out_side  = st_q[N-1].side;
	assign out_quo   = st_q[N-1].word;
	assign out_neg   = st_q[N-1].neg;
	assign out_dz    = (st_q[N-1].den == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[0]) v_q[0] <= in_valid;
			for (int k = 1; k < N; k++) begin
				if (en[k]) v_q[k] <= v_q[k-1];
			end
		end
	end

	// Dividend shifts out the top while quotient bits shift in the bottom
	for (genvar k = 0; k < N; k++) begin : g_stage
		dv_t src;
		if (k == 0) begin : g_first
			always_comb begin
				logic signed [NUM_W-1:0] mag;
				mag      = in_side.num[NUM_W-1] ? -in_side.num : in_side.num;
				src.side = in_side;
				src.den  = in_den;
				src.rem  = '0;
				src.word = mag[QUO_W-1:0];
				src.neg  = in_side.num[NUM_W-1];
			end
		end else begin : g_rest
			assign src = st_q[k-1];
		end

		always_comb begin
			logic [DEN_W:0] r2;
			r2    = {src.rem, src.word[QUO_W-1]};
			nx[k] = src;
			if (r2 >= {1'b0, src.den}) begin
				nx[k].rem  = DEN_W'(r2 - {1'b0, src.den});
				nx[k].word = {src.word[QUO_W-2:0], 1'b1};
			end else begin
				nx[k].rem  = r2[DEN_W-1:0];
				nx[k].word = {src.word[QUO_W-2:0], 1'b0};
			end
		end

		always_ff @(posedge clk) begin
			if (en[k]) st_q[k] <= nx[k];
		end
	end

endmodule

// ===== sv/optimizer_parameter_update.sv =====
// Optimizer parameter update: top level with final Adam step and output register.
//
// Per-parameter SGD / momentum / Adam update on signed Q8.24 data. One item
// is accepted per clock unless the pipeline is stalled, and one result comes
// out per item, in order. Every mode takes the same path: a six-stage multiply
// front end, a 28-stage square root (one root bit per stage), a 56-stage
// divider (one quotient bit per stage) and the output register. A stalled
// output backs the pipeline up stage by stage, so bubbles are squeezed out and
// input is still taken while a finished result waits. Settings live in an APB
// register file (registers at byte offsets 0x00..0x1C, pready always high)
// and must only be changed while no item is in flight.
module optimizer_parameter_update (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [opu_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  opu_pkg::data_t             param_value,
	input  opu_pkg::data_t             grad_value,
	input  opu_pkg::data_t             moment_one,
	input  opu_pkg::data_t             moment_two,
	output logic                       out_valid,
	input  logic                       out_ready,
	output opu_pkg::data_t             new_param,
	output opu_pkg::data_t             new_moment_one,
	output opu_pkg::data_t             new_moment_two,
	output logic                       saturated
);
	import opu_pkg::*;

	cfg_t             cfg;
	logic             f_valid, f_ready;
	side_t            f_side;
	logic [ARG_W-1:0] f_arg;
	logic             s_valid, s_ready;
	side_t            s_side;
	logic [DEN_W-1:0] s_den;
	logic             d_valid, d_ready;
	side_t            d_side;
	logic [QUO_W-1:0] d_quo;
	logic             d_neg, d_dz;
	logic             out_v_q;
	data_t            np_q, nm_q, nv_q;
	logic             flag_q;
	data_t            np_fin;
	logic             flag_fin;

	opu_cfg u_cfg (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
		.prdata, .pready, .cfg
	);

	opu_front u_front (
		.clk, .arst_n, .cfg,
		.in_valid, .in_ready,
		.p_in(param_value), .g_in(grad_value), .m_in(moment_one), .v_in(moment_two),
		.out_valid(f_valid), .out_ready(f_ready), .out_side(f_side), .out_arg(f_arg)
	);

	opu_sqrt u_sqrt (
		.clk, .arst_n, .cfg,
		.in_valid(f_valid), .in_ready(f_ready), .in_side(f_side), .in_arg(f_arg),
		.out_valid(s_valid), .out_ready(s_ready), .out_side(s_side), .out_den(s_den)
	);

	opu_div u_div (
		.clk, .arst_n,
		.in_valid(s_valid), .in_ready(s_ready), .in_side(s_side), .in_den(s_den),
		.out_valid(d_valid), .out_ready(d_ready), .out_side(d_side),
		.out_quo(d_quo), .out_neg(d_neg), .out_dz(d_dz)
	);

	// Apply the Adam step; other modes already carry their parameter
	always_comb begin
		logic signed [QUO_W:0] step;
		sat_t                  r;
		step     = d_neg ? -$signed({1'b0, d_quo}) : $signed({1'b0, d_quo});
		r        = sat_wide(WIDE_W'(d_side.p) - WIDE_W'(step));
		np_fin   = d_side.np;
		flag_fin = d_side.flag;
		if (d_side.mode == MODE_ADAM && !d_dz) begin
			np_fin   = r.val;
			flag_fin = d_side.flag | r.clip;
		end
	end

	assign d_ready = !out_v_q || out_ready;

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (d_ready) begin
			out_v_q <= d_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (d_ready) begin
			np_q   <= np_fin;
			nm_q   <= d_side.nm;
			nv_q   <= d_side.nv;
			flag_q <= flag_fin;
		end
	end

	assign out_valid      = out_v_q;
	assign new_param      = np_q;
	assign new_moment_one = nm_q;
	assign new_moment_two = nv_q;
	assign saturated      = flag_q;

endmodule

// ===== bench/opu_checker.sv =====
// Checker for the optimizer update block: mirrors the registers, predicts each result, compares.
module opu_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [opu_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	input  logic                       pready,
	input  logic                       in_valid,
	input  logic                       in_ready,
	input  opu_pkg::data_t             param_value,
	input  opu_pkg::data_t             grad_value,
	input  opu_pkg::data_t             moment_one,
	input  opu_pkg::data_t             moment_two,
	input  logic                       out_valid,
	input  logic                       out_ready,
	input  opu_pkg::data_t             new_param,
	input  opu_pkg::data_t             new_moment_one,
	input  opu_pkg::data_t             new_moment_two,
	input  logic                       saturated,
	output int                         errors,
	output int                         pending,
	output int                         checked
);
	timeunit 1ns;
	timeprecision 1ps;
	import opu_pkg::*;

	typedef struct {
		data_t np;
		data_t nm;
		data_t nv;
		logic  flag;
	} update_t;

	localparam longint DATA_HI = 64'sd2147483647;
	localparam longint DATA_LO = -64'sd2147483648;
	localparam longint ONE_Q24 = 64'sd1 << FRAC_W;

	logic [31:0] regs [8];
	update_t     updates_due [$];

	// Clip to the Q8.24 range, noting any clip
	function automatic longint clip(input longint x, inout bit f);
		if (x > DATA_HI) begin
			f = 1'b1;
			return DATA_HI;
		end
		if (x < DATA_LO) begin
			f = 1'b1;
			return DATA_LO;
		end
		return x;
	endfunction

	function automatic longint unsigned int_sqrt(input longint unsigned x);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// Updated parameter and moments for one item under the current settings
	function automatic update_t optimizer_step(input data_t pi, input data_t gi,
			input data_t mi, input data_t vi);
		update_t u;
		bit f;
		longint p, g, m, v, lr, mf, b1, b2, eps, c1, c2;
		longint np, nm, nv, g2, mh, vh, den;
		longint unsigned root;
		p = pi; g = gi; m = mi; v = vi;
		lr = regs[REG_LR]; mf = regs[REG_MF];
		b1 = regs[REG_B1]; b2 = regs[REG_B2]; eps = regs[REG_EPS];
		c1 = longint'({32'd0, regs[REG_C1]});
		c2 = longint'({32'd0, regs[REG_C2]});
		np = p; nm = m; nv = v;
		f = 1'b0;
		case (mode_t'(regs[REG_MODE][1:0]))
			MODE_SGD: begin
				np = clip(p - ((lr * g) >>> FRAC_W), f);
			end
			MODE_MOMENTUM: begin
				nv = clip((mf * v - lr * g) >>> FRAC_W, f);
				np = clip(p + nv, f);
			end
			MODE_ADAM: begin
				nm = clip((b1 * m + (ONE_Q24 - b1) * g) >>> FRAC_W, f);
				g2 = (g * g) >>> FRAC_W;
				nv = clip((b2 * v + (ONE_Q24 - b2) * g2) >>> FRAC_W, f);
				mh = clip((nm * c1) >>> CORR_W, f);
				vh = clip((nv * c2) >>> CORR_W, f);
				// negative corrected second moment takes a zero root
				root = (vh > 0) ? int_sqrt(longint'(vh) << FRAC_W) : 64'd0;
				den = longint'(root) + eps;
				// zero denominator leaves the weight alone
				if (den != 0) np = clip(p - (lr * mh) / den, f);
			end
			default: ;
		endcase
		u.np = data_t'(np);
		u.nm = data_t'(nm);
		u.nv = data_t'(nv);
		u.flag = f;
		return u;
	endfunction

	task automatic report(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0h want %0h (result %0d)", what, got, want, checked);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		update_t u;
		if (!arst_n) begin
			regs[REG_MODE] <= 32'd0;
			regs[REG_LR]   <= 32'd16777;
			regs[REG_MF]   <= 32'd15099494;
			regs[REG_B1]   <= 32'd15099494;
			regs[REG_B2]   <= 32'd16760439;
			regs[REG_EPS]  <= 32'd1;
			regs[REG_C1]   <= 32'd65536;
			regs[REG_C2]   <= 32'd65536;
			updates_due.delete();
			errors  <= 0;
			checked <= 0;
			pending <= 0;
		end else begin
			// register write mirror, masked to each register's width
			if (psel && penable && pwrite && pready && paddr[ADDR_W-1:2] < 8) begin
				case (reg_idx_t'(paddr[4:2])) inside
					REG_MODE:       regs[REG_MODE] <= pwdata & 32'h3;
					REG_C1, REG_C2: regs[paddr[4:2]] <= pwdata;
					default:        regs[paddr[4:2]] <= pwdata & 32'hFFFFFF;
				endcase
			end
			if (in_valid && in_ready)
				updates_due.push_back(optimizer_step(param_value, grad_value,
					moment_one, moment_two));
			if (out_valid && out_ready) begin
				if (updates_due.size() == 0) begin
					$display("unexpected result (result %0d)", checked);
					errors++;
				end else begin
					u = updates_due.pop_front();
					if (new_param !== u.np) report("new_param", new_param, u.np);
					if (new_moment_one !== u.nm) report("new_moment_one", new_moment_one, u.nm);
					if (new_moment_two !== u.nv) report("new_moment_two", new_moment_two, u.nv);
					if (saturated !== u.flag) report("saturated", saturated, u.flag);
				end
				checked <= checked + 1;
			end
			pending <= updates_due.size();
		end
	end
endmodule

// ===== bench/tb_optimizer_parameter_update.sv =====
// Testbench top: drives settings and items into the optimizer update block and gives the verdict.
module tb_optimizer_parameter_update;
	timeunit 1ns;
	timeprecision 1ps;
	import opu_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0]       pwdata = '0;
	logic [31:0]       prdata;
	logic              pready;
	logic              in_valid = 1'b0, in_ready;
	data_t             param_value = '0, grad_value = '0, moment_one = '0, moment_two = '0;
	logic              out_valid, out_ready = 1'b0;
	data_t             new_param, new_moment_one, new_moment_two;
	logic              saturated;
	int                errors, pending, checked;
	int                cycles = 0;
	int                items_sent = 0;
	int                burst_left = 0;
	int                hold_asks = 0;

	always #5 clk = ~clk;

	optimizer_parameter_update dut (.*);

	opu_checker u_checker (.*);

	// Run-length guard
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("status: fail");
			$finish;
		end
	end

	// Result side: long hold-offs on request, otherwise a changing stall pattern
	initial begin
		int hold_seen;
		int hold_left;
		int style;
		int style_left;
		hold_seen = 0; hold_left = 0; style = 0; style_left = 0;
		forever begin
			@(negedge clk);
			if (hold_asks != hold_seen) begin
				hold_seen = hold_asks;
				hold_left = 300;
			end
			if (style_left == 0) begin
				style = $urandom_range(0, 2);
				style_left = $urandom_range(20, 120);
			end
			style_left--;
			if (hold_left > 0) begin
				hold_left--;
				out_ready = 1'b0;
			end else begin
				case (style)
					0: out_ready = 1'b1;
					1: out_ready = $urandom_range(0, 1);
					default: out_ready = ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	task automatic cfg_write(input reg_idx_t idx, input logic [31:0] val);
		psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
		paddr = {idx, 2'b00}; pwdata = val;
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
	endtask

	// Present one item, wait for it to be taken, then maybe open a gap
	task automatic send_item(input data_t p, input data_t g, input data_t m, input data_t v);
		param_value = p; grad_value = g; moment_one = m; moment_two = v;
		in_valid = 1'b1;
		#1;
		while (!in_ready) begin
			@(negedge clk);
			#1;
		end
		@(posedge clk);
		items_sent++;
		@(negedge clk);
		if (burst_left == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8)) @(negedge clk);
			burst_left = $urandom_range(1, 40);
		end else begin
			burst_left--;
		end
	endtask

	function automatic data_t rand_data(input bit positive);
		data_t d;
		case ($urandom_range(0, 5))
			0, 1: d = $urandom;
			2, 3: d = $signed($urandom_range(0, 32'h07FF_FFFF)) - 32'sh0400_0000;
			4: d = $signed($urandom_range(0, 32'h01FF_FFFF)) - 32'sh0100_0000;
			default: case ($urandom_range(0, 3))
				0: d = 32'sh7FFF_FFFF;
				1: d = 32'sh8000_0000;
				2: d = '0;
				default: d = -1;
			endcase
		endcase
		if (positive && d < 0) d = -(d + 1);
		return d;
	endfunction

	task automatic directed_items();
		send_item(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
		send_item(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
		send_item(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0100_0000, -32'sh0100_0000);
		send_item('0, '0, '0, '0);
		send_item(32'sh0100_0000, '0, 32'sh0100_0000, -32'sh0000_1000);
		send_item(-1, 1, -1, 1);
	endtask

	task automatic random_items(input int n);
		bit adam_like;
		for (int i = 0; i < n; i++) begin
			// most items look like live training data, the rest are raw noise
			adam_like = ($urandom_range(0, 3) != 0);
			send_item(rand_data(1'b0), rand_data(1'b0), rand_data(1'b0), rand_data(adam_like));
		end
	endtask

	// Wait for every result, then let the pipeline drain
	task automatic settle();
		in_valid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (100) @(negedge clk);
	endtask

	initial begin
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset settings: plain SGD
		directed_items();
		random_items(150);
		settle();

		// SGD at the largest rate, with junk above the register width
		cfg_write(REG_LR, 32'hFFFF_FFFF);
		cfg_write(REG_MODE, {30'($urandom_range(0, 32'h3FFF_FFFF)), MODE_SGD});
		hold_asks++;
		random_items(200);
		settle();

		// SGD at zero rate
		cfg_write(REG_LR, 32'd0);
		random_items(150);
		settle();

		// momentum, full decay and random rate
		cfg_write(REG_MODE, 32'(MODE_MOMENTUM));
		cfg_write(REG_MF, 32'hFF_FFFF);
		cfg_write(REG_LR, $urandom_range(0, 32'hFF_FFFF));
		random_items(180);
		settle();

		// momentum, no decay, largest rate
		cfg_write(REG_MF, 32'd0);
		cfg_write(REG_LR, 32'hFF_FFFF);
		directed_items();
		random_items(150);
		settle();

		// Adam at reset-like decays, moderate corrections
		cfg_write(REG_MODE, 32'(MODE_ADAM));
		cfg_write(REG_LR, 32'd16777);
		cfg_write(REG_C1, $urandom_range(65536, 32'h000A_0000));
		cfg_write(REG_C2, $urandom_range(65536, 32'h0100_0000));
		hold_asks++;
		random_items(220);
		settle();

		// Adam extremes: no first decay, full second decay, no epsilon
		cfg_write(REG_B1, 32'd0);
		cfg_write(REG_B2, 32'hFF_FFFF);
		cfg_write(REG_EPS, 32'd0);
		cfg_write(REG_C1, 32'hFFFF_FFFF);
		cfg_write(REG_C2, 32'hFFFF_FFFF);
		directed_items();
		random_items(180);
		settle();

		// Adam other extremes
		cfg_write(REG_B1, 32'hFF_FFFF);
		cfg_write(REG_B2, 32'd0);
		cfg_write(REG_EPS, 32'hFF_FFFF);
		cfg_write(REG_C1, 32'd65536);
		cfg_write(REG_C2, 32'd65536);
		cfg_write(REG_LR, 32'hFF_FFFF);
		random_items(180);
		settle();

		// Adam with random settings
		cfg_write(REG_B1, $urandom_range(0, 32'hFF_FFFF));
		cfg_write(REG_B2, $urandom_range(0, 32'hFF_FFFF));
		cfg_write(REG_EPS, $urandom_range(0, 32'h00_FFFF));
		cfg_write(REG_C1, $urandom);
		cfg_write(REG_C2, $urandom_range(65536, 32'h0010_0000));
		cfg_write(REG_LR, $urandom_range(0, 32'hFF_FFFF));
		random_items(180);
		settle();

		// unused mode: everything passes through
		cfg_write(REG_MODE, 32'(MODE_NONE));
		directed_items();
		random_items(120);
		settle();

		$display("%0d items over ten settings (SGD, momentum, Adam extremes, unused mode)",
			items_sent);
		$display("%0d results checked, %0d mismatches", checked, errors);
		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end
endmodule
